/* sv/global_alignment_score_top_assert.svh */
// ----------------------------------------------------------------------------
// global alignment score: assertion macros
// shared property forms for the score block checks
// ----------------------------------------------------------------------------
`ifndef GLOBAL_ALIGNMENT_SCORE_TOP_ASSERT_SVH
`define GLOBAL_ALIGNMENT_SCORE_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GAS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define GAS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/gas_pkg.sv */
// ----------------------------------------------------------------------------
// gas_pkg
// sizes, shared types and score helpers for the global alignment score block
// ----------------------------------------------------------------------------
`default_nettype none

package gas_pkg;

  localparam int MAX_LEN = 64;
  localparam int IDX_W   = $clog2(MAX_LEN + 1);
  localparam int POS_W   = $clog2(MAX_LEN);
  localparam int SCORE_W = 12;
  localparam int SYM_W   = 8;
  localparam int MATCH_W = 4;
  localparam int PEN_W   = 5;
  localparam int QLEN_W  = 7;
  localparam int SUM_W   = SCORE_W + 2;
  localparam int PROD_W  = IDX_W + 1 + PEN_W;
  localparam int WIDE_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;

  localparam logic [MATCH_W-1:0]        MATCH_RESET    = MATCH_W'(1);
  localparam logic signed [PEN_W-1:0]   MISMATCH_RESET = '1;
  localparam logic signed [PEN_W-1:0]   GAP_RESET      = '1;

  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0]  WIDE_MIN  = WIDE_W'(-(2 ** (SCORE_W - 1)));
  localparam logic signed [WIDE_W-1:0]  WIDE_MAX  = WIDE_W'(2 ** (SCORE_W - 1) - 1);

  // input action carried in tuser
  typedef enum logic {ACT_LOAD = 1'b0, ACT_QUERY = 1'b1} action_t;

  // register indexes of the write channel
  typedef enum logic [1:0] {
    REG_MATCH    = 2'd0,
    REG_MISMATCH = 2'd1,
    REG_GAP      = 2'd2
  } cfg_reg_t;

  // token moving down the cell chain, one cell per cycle
  typedef struct packed {
    logic                      valid;
    logic                      upd;   // 1 compute a row, 0 only fetch the corner
    logic [SYM_W-1:0]          sym;
    logic signed [SCORE_W-1:0] left;  // new score of the previous cell
    logic signed [SCORE_W-1:0] diag;  // old score of the previous cell
  } tok_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic                      clear;
    logic                      wr_en;
    logic [POS_W-1:0]          wr_pos;
    logic [SYM_W-1:0]          wr_sym;
    logic [IDX_W-1:0]          ref_len;
    logic [MATCH_W-1:0]        match;
    logic signed [PEN_W-1:0]   mismatch;
    logic signed [PEN_W-1:0]   gap;
  } cell_ctl_t;

  function automatic logic signed [SCORE_W-1:0] clamp_score(
    input logic signed [WIDE_W-1:0] v
  );
    if (v < WIDE_MIN) return SCORE_MIN;
    if (v > WIDE_MAX) return SCORE_MAX;
    return v[SCORE_W-1:0];
  endfunction

  // border value idx * gap, saturated
  function automatic logic signed [SCORE_W-1:0] border_score(
    input logic [IDX_W-1:0]      idx,
    input logic signed [PEN_W-1:0] gap
  );
    logic signed [PROD_W-1:0] p;
    p = signed'({1'b0, idx}) * gap;
    return clamp_score(WIDE_W'(p));
  endfunction

endpackage

`default_nettype wire

/* sv/global_alignment_score_top.sv */
// ----------------------------------------------------------------------------
// global_alignment_score_top
// needleman-wunsch global alignment score, linear gap, systolic cell chain
// ----------------------------------------------------------------------------
// usage
//   s_* stream: tdata = symbol, tuser = action (0 load reference, 1 query),
//   tlast = last symbol of the sequence being sent
//   m_* stream: one transfer per query ending in tlast, carrying the corner
//   score, the query length and the dropped-symbol flag
//   cfg_* channel: register writes (match, mismatch, gap), always ready
// timing
//   input stays ready across a load transfer; a query transfer that computes a
//   row, or a last one, blocks input while its token walks the chain
//   a last query reaches m_tvalid through the chain end and the finish state
// reset
//   cells load border scores index * (-1), lengths, counters and flags clear,
//   registers take their defaults; no clearing pass is needed
// stall
//   a finished result waits in the output register while new input is taken;
//   a second result that finds it still full holds in the finish state and
//   keeps s_tready low until m_tready frees the register
// ----------------------------------------------------------------------------
`default_nettype none

`include "global_alignment_score_top_assert.svh"

module global_alignment_score_top import gas_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // input stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [SYM_W-1:0]    s_tdata,   // [7:0] symbol
  input  logic                s_tuser,   // [0] action
  input  logic                s_tlast,
  // result stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [23:0]         m_tdata,   // [11:0] score, [18:12] query_length, rest zero
  output logic                m_tuser,   // [0] overflow
  // register writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [PEN_W-1:0]    cfg_data
);

  localparam int         OUT_PAD_W    = 24 - SCORE_W - QLEN_W;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FINISH} state_t;

  state_t                    state;
  logic [MATCH_W-1:0]        match_score;
  logic signed [PEN_W-1:0]   mismatch_score;
  logic signed [PEN_W-1:0]   gap_score;
  logic [IDX_W-1:0]          ref_len;
  logic                      ref_done;
  logic                      dropped;
  logic [IDX_W-1:0]          qc;         // query rows done
  logic signed [SCORE_W-1:0] border0;    // current left border score
  logic                      last_q;
  logic signed [SCORE_W-1:0] corner;
  tok_t                      tok_head;

  tok_t                      tokens [0:MAX_LEN];
  cell_ctl_t                 ctl;

  logic                      in_fire;
  logic                      load_fire;
  logic                      query_fire;
  logic                      row_launch;
  logic                      finish_fire;
  logic [IDX_W-1:0]          eff_len;
  logic                      space;
  logic signed [SCORE_W-1:0] next_border0;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    in_fire      = s_tvalid && s_tready;
    load_fire    = in_fire && (s_tuser == ACT_LOAD);
    query_fire   = in_fire && (s_tuser == ACT_QUERY);
    // a query that still fits computes a row
    row_launch   = query_fire && (qc < IDX_W'(MAX_LEN));
    finish_fire  = (state == S_FINISH) && (!m_tvalid || m_tready);
    // a load after a finished reference starts a new one
    eff_len      = ref_done ? '0 : ref_len;
    space        = eff_len < IDX_W'(MAX_LEN);
    next_border0 = border_score(qc + IDX_W'(1), gap_score);

    ctl.clear    = load_fire || finish_fire;
    ctl.wr_en    = load_fire && space;
    ctl.wr_pos   = eff_len[POS_W-1:0];
    ctl.wr_sym   = s_tdata;
    ctl.ref_len  = ref_len;
    ctl.match    = match_score;
    ctl.mismatch = mismatch_score;
    ctl.gap      = gap_score;
  end

  assign tokens[0] = tok_head;

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    gas_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .pos     (POS_W'(k)),
      .ctl     (ctl),
      .tok_in  (tokens[k]),
      .tok_out (tokens[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      match_score    <= MATCH_RESET;
      mismatch_score <= MISMATCH_RESET;
      gap_score      <= GAP_RESET;
      ref_len        <= '0;
      ref_done       <= 1'b0;
      dropped        <= 1'b0;
      qc             <= '0;
      border0        <= '0;
      last_q         <= 1'b0;
      tok_head.valid <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      // a token enters the chain for a row, or for the corner of a last query
      tok_head.valid <= row_launch || (query_fire && s_tlast);
      if (finish_fire)   m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MATCH:    match_score    <= cfg_data[MATCH_W-1:0];
          REG_MISMATCH: mismatch_score <= signed'(cfg_data);
          REG_GAP:      gap_score      <= signed'(cfg_data);
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (load_fire) begin
            ref_len  <= space ? eff_len + IDX_W'(1) : eff_len;
            dropped  <= (dropped && !ref_done) || !space;
            ref_done <= s_tlast;
            qc       <= '0;
            border0  <= '0;
          end else if (query_fire) begin
            tok_head.sym   <= s_tdata;
            last_q         <= s_tlast;
            if (qc < IDX_W'(MAX_LEN)) begin
              tok_head.upd  <= 1'b1;
              tok_head.left <= next_border0;
              tok_head.diag <= border0;
              border0       <= next_border0;
              qc            <= qc + IDX_W'(1);
              state         <= S_RUN;
            end else begin
              // query too long: symbol dropped, last still fetches the corner
              dropped       <= 1'b1;
              tok_head.upd  <= 1'b0;
              tok_head.left <= border0;
              tok_head.diag <= border0;
              if (s_tlast) state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (tokens[MAX_LEN].valid) begin
            corner <= tokens[MAX_LEN].left;
            state  <= last_q ? S_FINISH : S_IDLE;
          end
        end
        S_FINISH: begin
          if (finish_fire) begin
            m_tdata  <= {{OUT_PAD_W{1'b0}}, QLEN_W'(qc), corner};
            m_tuser  <= dropped;
            dropped  <= 1'b0;
            qc       <= '0;
            border0  <= '0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // chain output only shows up in the run state
  `GAS_ASSERT_IMP(a_tok_in_run, tokens[MAX_LEN].valid, state == S_RUN, "token outside run")
  // reference length never passes the cell count
  `GAS_ASSERT_IMP(a_len_bound, 1'b1, ref_len <= IDX_W'(MAX_LEN), "reference too long")
  // a result leaves the query cleared behind it
  `GAS_ASSERT_NXT(a_finish_clear, finish_fire, m_tvalid && qc == '0 && border0 == '0, "no clear")
  // a computed row blocks input until its token is through
  `GAS_ASSERT_NXT(a_row_busy, row_launch, !s_tready && tok_head.valid, "input not held")

endmodule

`default_nettype wire

/* sv/gas_cell.sv */
// ----------------------------------------------------------------------------
// gas_cell
// one column of the score matrix: reference symbol, score and chain token
// ----------------------------------------------------------------------------
`default_nettype none

module gas_cell import gas_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [POS_W-1:0] pos,
  input  cell_ctl_t        ctl,
  input  tok_t             tok_in,
  output tok_t             tok_out
);

  logic [SYM_W-1:0]          ref_sym;
  logic signed [SCORE_W-1:0] score;

  logic                      active;
  logic signed [PEN_W-1:0]   border_gap;
  logic signed [SCORE_W-1:0] border_val;
  logic signed [PEN_W-1:0]   sub;
  logic signed [WIDE_W-1:0]  cand_up;
  logic signed [WIDE_W-1:0]  cand_left;
  logic signed [WIDE_W-1:0]  cand_diag;
  logic signed [WIDE_W-1:0]  best;
  logic signed [SCORE_W-1:0] new_score;

  always_comb begin
    active     = IDX_W'(pos) < ctl.ref_len;
    border_gap = rst ? GAP_RESET : ctl.gap;
    border_val = border_score(IDX_W'(pos) + IDX_W'(1), border_gap);
    sub        = (ref_sym == tok_in.sym) ? signed'({1'b0, ctl.match}) : ctl.mismatch;
    cand_up    = WIDE_W'(score) + WIDE_W'(ctl.gap);
    cand_left  = WIDE_W'(tok_in.left) + WIDE_W'(ctl.gap);
    cand_diag  = WIDE_W'(tok_in.diag) + WIDE_W'(sub);
    best       = (cand_up > cand_left) ? cand_up : cand_left;
    if (cand_diag > best) best = cand_diag;
    new_score  = clamp_score(best);
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en && ctl.wr_pos == pos) ref_sym <= ctl.wr_sym;

    if (rst || ctl.clear) begin
      score <= border_val;
    end else if (tok_in.valid && tok_in.upd && active) begin
      score <= new_score;
    end

    if (rst) tok_out.valid <= 1'b0;
    else     tok_out.valid <= tok_in.valid;
    tok_out.upd <= tok_in.upd;
    tok_out.sym <= tok_in.sym;
    if (active) begin
      tok_out.left <= tok_in.upd ? new_score : score;
      tok_out.diag <= score;
    end else begin
      // past the reference end the corner value rides along unchanged
      tok_out.left <= tok_in.left;
      tok_out.diag <= tok_in.diag;
    end
  end

endmodule

`default_nettype wire

/* dv/tb_global_alignment_score_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_global_alignment_score_top
// self-checking bench for the global alignment score block: a behavioral
// score tracker follows every accepted symbol and predicts the corner score,
// dropped-symbol flag and query length of each result; directed sequences
// come first, then random reference/query runs under several score settings
// and both-side backpressure
// ----------------------------------------------------------------------------

module tb_global_alignment_score_top;
  import gas_pkg::*;

  typedef struct {
    logic signed [SCORE_W-1:0] score;
    logic                      overflow;
    logic [QLEN_W-1:0]         qlen;
  } corner_t;

  localparam int SETTLE_CYCLES  = 2 * MAX_LEN + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SEGMENTS       = 6;
  localparam int SEG_ITEMS      = 155;

  // predicts the corner score of each finished query
  class corner_score_tracker;
    logic [SYM_W-1:0]        ref_sym [MAX_LEN];
    int                      ref_len;
    int                      qry_cnt;
    bit                      dropped;
    bit                      ref_closed;
    int                      row [MAX_LEN+1];
    logic [MATCH_W-1:0]      match_r;
    logic signed [PEN_W-1:0] mism_r;
    logic signed [PEN_W-1:0] gap_r;
    corner_t                 corner_queue[$];
    int                      fails;

    function int clamp_cell(int v);
      if (v < -(2 ** (SCORE_W - 1))) return -(2 ** (SCORE_W - 1));
      if (v > 2 ** (SCORE_W - 1) - 1) return 2 ** (SCORE_W - 1) - 1;
      return v;
    endfunction

    function void restart_rows();
      for (int j = 0; j <= MAX_LEN; j++) row[j] = clamp_cell(j * int'(gap_r));
      qry_cnt = 0;
    endfunction

    function void reset_state();
      ref_len    = 0;
      dropped    = 0;
      ref_closed = 0;
      match_r    = MATCH_W'(1);
      mism_r     = '1;
      gap_r      = '1;
      fails      = 0;
      corner_queue.delete();
      restart_rows();
    endfunction

    function void set_reg(cfg_reg_t idx, logic [PEN_W-1:0] val);
      case (idx)
        REG_MATCH:    match_r = val[MATCH_W-1:0];
        REG_MISMATCH: mism_r  = val;
        REG_GAP:      gap_r   = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return corner_queue.size();
    endfunction

    // one accepted input symbol
    function void take_symbol(action_t act, logic [SYM_W-1:0] sym, bit lst);
      int      g;
      int      diag;
      int      up;
      int      step;
      int      best;
      corner_t c;
      g = int'(gap_r);
      if (act == ACT_LOAD) begin
        // a load after a closed reference starts a new one
        if (ref_closed) begin
          ref_len    = 0;
          ref_closed = 0;
          dropped    = 0;
        end
        if (ref_len < MAX_LEN) begin
          ref_sym[ref_len] = sym;
          ref_len++;
        end else begin
          dropped = 1;
        end
        if (lst) ref_closed = 1;
        restart_rows();
        return;
      end
      if (qry_cnt < MAX_LEN) begin
        diag   = row[0];
        row[0] = clamp_cell((qry_cnt + 1) * g);
        for (int j = 1; j <= ref_len; j++) begin
          up   = row[j];
          step = (ref_sym[j-1] == sym) ? int'(match_r) : int'(mism_r);
          best = up + g;
          if (row[j-1] + g > best) best = row[j-1] + g;
          if (diag + step > best) best = diag + step;
          diag   = up;
          row[j] = clamp_cell(best);
        end
        qry_cnt++;
      end else begin
        dropped = 1;
      end
      if (!lst) return;
      c.score    = SCORE_W'(row[ref_len]);
      c.overflow = dropped;
      c.qlen     = QLEN_W'(qry_cnt);
      corner_queue.push_back(c);
      dropped = 0;
      restart_rows();
    endfunction

    function void check_corner(logic [SCORE_W-1:0] score, logic ovf, logic [QLEN_W-1:0] qlen);
      corner_t exp_c;
      if (corner_queue.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected result: score %0d overflow %0b length %0d",
                   $signed(score), ovf, qlen);
        return;
      end
      exp_c = corner_queue.pop_front();
      if (score !== exp_c.score || ovf !== exp_c.overflow || qlen !== exp_c.qlen) begin
        fails++;
        if (fails <= 10)
          $display({"result mismatch: expected score %0d overflow %0b length %0d, ",
                    "got score %0d overflow %0b length %0d"},
                   exp_c.score, exp_c.overflow, exp_c.qlen, $signed(score), ovf, qlen);
      end
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               s_tvalid  = 1'b0;
  logic               s_tready;
  logic [SYM_W-1:0]   s_tdata   = '0;
  logic               s_tuser   = 1'b0;
  logic               s_tlast   = 1'b0;
  logic               m_tvalid;
  logic               m_tready  = 1'b0;
  logic [23:0]        m_tdata;   // [11:0] score, [18:12] query_length
  logic               m_tuser;   // [0] overflow
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [PEN_W-1:0]   cfg_data  = '0;

  corner_score_tracker tracker;
  int send_idle_pct = 12;
  int recv_idle_pct = 77;
  int items_sent    = 0;
  int idle_cycles   = 0;

  global_alignment_score_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // result side backpressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // result checking
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      tracker.check_corner(m_tdata[11:0], m_tuser, m_tdata[18:12]);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("global_alignment_score_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(action_t act, logic [SYM_W-1:0] sym, bit lst);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= sym;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.take_symbol(act, sym, lst);
    items_sent++;
  endtask

  function automatic logic [SYM_W-1:0] pick_symbol(int alpha);
    if (alpha == 0) return SYM_W'($urandom_range(0, 255));
    return SYM_W'(8'h41 + $urandom_range(0, alpha - 1));
  endfunction

  // mostly short sequences, now and then one near or past the length limit
  function automatic int pick_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(MAX_LEN - 4, MAX_LEN + 6);
    return $urandom_range(1, 16);
  endfunction

  task automatic send_run(action_t act, int len, int alpha, bit close);
    for (int i = 0; i < len; i++) send_item(act, pick_symbol(alpha), close && (i == len - 1));
  endtask

  // let the chain finish before touching registers
  task automatic settle();
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [PEN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_reg(idx, val);
  endtask

  task automatic apply_setting(int m, int mm, int g);
    write_reg(REG_MATCH, PEN_W'(m));
    write_reg(REG_MISMATCH, PEN_W'(mm));
    write_reg(REG_GAP, PEN_W'(g));
    cfg_valid <= 1'b0;
  endtask

  task automatic one_sequence();
    int kind;
    int alpha;
    kind  = $urandom_range(0, 99);
    alpha = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 4);
    if (kind < 75) begin
      // closed reference followed by a few complete queries
      send_run(ACT_LOAD, pick_len(), alpha, 1'b1);
      repeat ($urandom_range(1, 4)) send_run(ACT_QUERY, pick_len(), alpha, 1'b1);
    end else if (kind < 85) begin
      repeat ($urandom_range(1, 6))
        send_item(action_t'($urandom_range(0, 1)), pick_symbol(0), $urandom_range(0, 3) == 0);
    end else if (kind < 93) begin
      // query cut off by a new reference
      send_run(ACT_QUERY, $urandom_range(1, 8), alpha, 1'b0);
      send_run(ACT_LOAD, $urandom_range(1, 8), alpha, 1'b1);
      send_run(ACT_QUERY, pick_len(), alpha, 1'b1);
    end else begin
      // query against a reference still open
      send_run(ACT_LOAD, $urandom_range(0, 6), alpha, 1'b0);
      send_run(ACT_QUERY, pick_len(), alpha, 1'b1);
    end
  endtask

  initial begin
    int seg_start;
    tracker = new();
    tracker.reset_state();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty reference, byte extremes, exact match, mismatch,
    // load during a query, query on an open reference
    send_item(ACT_QUERY, 8'h41, 1'b1);
    send_item(ACT_LOAD, 8'h00, 1'b0);
    send_item(ACT_LOAD, 8'hFF, 1'b0);
    send_item(ACT_LOAD, 8'h5A, 1'b1);
    send_item(ACT_QUERY, 8'h00, 1'b0);
    send_item(ACT_QUERY, 8'hFF, 1'b0);
    send_item(ACT_QUERY, 8'h5A, 1'b1);
    send_item(ACT_QUERY, 8'hA5, 1'b1);
    send_item(ACT_QUERY, 8'h5A, 1'b0);
    send_item(ACT_LOAD, 8'h11, 1'b1);
    send_item(ACT_QUERY, 8'h11, 1'b1);
    send_item(ACT_LOAD, 8'h22, 1'b0);
    send_item(ACT_QUERY, 8'h22, 1'b1);
    send_item(ACT_LOAD, 8'h33, 1'b1);
    send_item(ACT_QUERY, 8'h22, 1'b0);
    send_item(ACT_QUERY, 8'h33, 1'b1);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      case (seg)
        0: apply_setting(15, -15, -15);
        1: apply_setting(0, 0, 0);
        3: apply_setting(15, 0, -15);
        4: apply_setting(3, 7, -16);   // raw register bits beyond the usual score range
        default: apply_setting($urandom_range(0, 15), -$urandom_range(0, 15),
                               -$urandom_range(0, 15));
      endcase
      send_idle_pct = (seg < 2) ? 12 : (seg < 4) ? 77 : 0;
      recv_idle_pct = (seg < 2) ? 77 : (seg < 4) ? 12 : 0;
      seg_start = items_sent;
      if (seg == 0) begin
        // both length limits crossed once for sure
        send_run(ACT_LOAD, MAX_LEN + 6, 3, 1'b1);
        send_run(ACT_QUERY, MAX_LEN + 4, 3, 1'b1);
      end
      while (items_sent - seg_start < SEG_ITEMS) one_sequence();
    end

    settle();
    if (tracker.fails == 0 && tracker.pending() == 0) begin
      $display("global_alignment_score_top test passed");
    end else begin
      $display("global_alignment_score_top test failed");
    end
    $finish;
  end

endmodule
